FILE: design/uitf_pkg.sv
// Package for the UART idle-timeout framer: request codes, register indexes,
// field widths, reset values and the pipeline stage record.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package uitf_pkg;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_BYTE    = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_READ    = 2'd2,
        REQ_RELEASE = 2'd3
    } req_type_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDLE_TIMEOUT = 2'd0,
        CFG_TICK_PERIOD  = 2'd1
    } cfg_index_t;

    // Field widths fixed by the interface.
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 9;
    localparam int TIMEOUT_W = 16;
    localparam int PERIOD_W  = 10;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd20;
    localparam logic [PERIOD_W-1:0]  TICK_PERIOD_RST  = 10'd1;

    // Default frame buffer depth in bytes (per bank).
    localparam int DEF_BUF_DEPTH = 256;

    // Result fields held between the state update and the output register.
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] len;
        logic             rd_hit;
        logic             pending;
    } stage_t;

endpackage

FILE: design/uitf_if.sv
// Channel interfaces of the UART idle-timeout framer: request, response and
// configuration write. Depends on uitf_pkg.
`timescale 1ns / 1ps

// Request channel: one word per received byte, tick, read or release.
interface uitf_req_if
    import uitf_pkg::*;
();
    logic               valid;
    logic               ready;
    req_type_t          req_type;
    logic [BYTE_W-1:0]  rx_byte;
    logic [POS_W-1:0]   read_index;

    modport source (output valid, output req_type, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input read_index,
                    output ready);
endinterface

// Response channel: one word per request.
interface uitf_rsp_if
    import uitf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               frame_done;
    logic [POS_W-1:0]   frame_len;
    logic [BYTE_W-1:0]  read_data;
    logic               frame_pending;

    modport source (output valid, output frame_done, output frame_len, output read_data,
                    output frame_pending, input ready);
    modport sink   (input valid, input frame_done, input frame_len, input read_data,
                    input frame_pending, output ready);
endinterface

// Configuration write channel.
interface uitf_cfg_if
    import uitf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/uart_idle_timeout_framer.sv
// Top level of the UART idle-timeout framer: state update, two-bank byte
// store and the response pipeline. Depends on uitf_pkg and uitf_if.sv.
//
// Channel  Role    Word contents
// -------  ------  ---------------------------------------------------
// req      sink    req_type, rx_byte, read_index
// rsp      source  frame_done, frame_len, read_data, frame_pending
// cfg      sink    index (0 idle_timeout, 1 tick_period), data
//
// One request word is accepted per cycle unless the middle stage is stalled;
// a response moves from the middle stage and read port to the output register.
// Reset clears the index, timeout, bank, length and pending state at once;
// the byte store is not cleared and needs no sweep. A stalled response holds
// in the output register while one more word can sit in the middle stage.
// The configuration port is always ready.
`timescale 1ns / 1ps

module uart_idle_timeout_framer
    import uitf_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
)(
    input  logic       clk,
    input  logic       rst_n,
    uitf_req_if.sink   req,
    uitf_rsp_if.source rsp,
    uitf_cfg_if.sink   cfg
);

    // Widths derived from the buffer depth.
    localparam int LW  = $clog2(BUF_DEPTH + 1);
    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int MAW = $clog2(2 * BUF_DEPTH);
    localparam int CW  = (LW > POS_W) ? LW : POS_W;
    localparam int MEM_DEPTH = 2 * BUF_DEPTH;
    localparam logic [MAW-1:0] BANK_OFS = MAW'(BUF_DEPTH);
    localparam logic [LW-1:0]  DEPTH_L  = LW'(BUF_DEPTH);
    localparam logic [CW-1:0]  DEPTH_C  = CW'(BUF_DEPTH);

    // Configuration registers.
    logic [TIMEOUT_W-1:0] idle_timeout_reg;
    logic [PERIOD_W-1:0]  tick_period_reg;

    // Framer state.
    logic                 bank_reg, bank_next;
    logic [LW-1:0]        wr_index_reg, wr_index_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [LW-1:0]        ready_len_reg, ready_len_next;
    logic                 pending_reg, pending_next;

    // Pipeline registers.
    logic                 s1_valid_reg, s1_valid_next;
    stage_t               s1_reg, s1_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_done_reg;
    logic [POS_W-1:0]     out_len_reg;
    logic [BYTE_W-1:0]    out_data_reg;
    logic                 out_pending_reg;

    // Byte store.
    logic [BYTE_W-1:0]    mem [0:MEM_DEPTH-1];
    logic [BYTE_W-1:0]    mem_rd_reg;
    logic                 mem_we;
    logic [MAW-1:0]       mem_wa;
    logic                 mem_re;
    logic [MAW-1:0]       mem_ra;

    // Handshake control.
    logic                 accept;
    logic                 out_load;

    // Helper values for the update.
    logic [LW-1:0]        wr_slot;
    logic [TIMEOUT_W-1:0] period_ext;
    logic [TIMEOUT_W-1:0] timeout_sub;
    logic [CW-1:0]        ridx_ext;
    logic [CW-1:0]        len_ext;
    logic                 rd_hit;

    // Pipeline flow: the middle stage moves when the output register is free.
    assign out_load  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || out_load;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Shared helper values.
    assign wr_slot     = (wr_index_reg >= DEPTH_L) ? '0 : wr_index_reg;
    assign period_ext  = TIMEOUT_W'(tick_period_reg);
    assign timeout_sub = timeout_reg - period_ext;
    assign ridx_ext    = CW'(req.read_index);
    assign len_ext     = CW'(ready_len_reg);
    assign rd_hit      = (ridx_ext < len_ext) && (ridx_ext < DEPTH_C);

    // State update for the accepted word, decoded by request type.
    always_comb
    begin
        bank_next      = bank_reg;
        wr_index_next  = wr_index_reg;
        timeout_next   = timeout_reg;
        ready_len_next = ready_len_reg;
        pending_next   = pending_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wa         = bank_reg ? (MAW'(wr_slot) + BANK_OFS) : MAW'(wr_slot);
        mem_ra         = !bank_reg ? (MAW'(ridx_ext[AW-1:0]) + BANK_OFS)
                                   : MAW'(ridx_ext[AW-1:0]);
        s1_next.done   = 1'b0;
        s1_next.rd_hit = 1'b0;

        if (accept)
        begin
            unique case (req.req_type)
                REQ_BYTE:
                begin
                    timeout_next  = idle_timeout_reg;
                    mem_we        = 1'b1;
                    wr_index_next = wr_slot + LW'(1);
                end
                REQ_TICK:
                begin
                    if (timeout_reg >= period_ext)
                    begin
                        timeout_next = timeout_sub;
                        // Timeout expired: capture the frame unless one is pending.
                        if (timeout_sub < period_ext)
                        begin
                            timeout_next = '0;
                            if (!pending_reg)
                            begin
                                ready_len_next = wr_index_reg;
                                bank_next      = !bank_reg;
                                pending_next   = 1'b1;
                                wr_index_next  = '0;
                                s1_next.done   = 1'b1;
                            end
                        end
                    end
                end
                REQ_READ:
                begin
                    mem_re         = rd_hit;
                    s1_next.rd_hit = rd_hit;
                end
                REQ_RELEASE:
                begin
                    pending_next = 1'b0;
                end
            endcase
        end

        s1_next.len     = POS_W'(ready_len_next);
        s1_next.pending = pending_next;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            tick_period_reg  <= TICK_PERIOD_RST;
            bank_reg         <= 1'b0;
            wr_index_reg     <= '0;
            timeout_reg      <= '0;
            ready_len_reg    <= '0;
            pending_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg.data;
                    CFG_TICK_PERIOD:  tick_period_reg  <= cfg.data[PERIOD_W-1:0];
                    default:          ;
                endcase
            end
            bank_reg      <= bank_next;
            wr_index_reg  <= wr_index_next;
            timeout_reg   <= timeout_next;
            ready_len_reg <= ready_len_next;
            pending_reg   <= pending_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (out_load)
        begin
            out_done_reg    <= s1_reg.done;
            out_len_reg     <= s1_reg.len;
            out_data_reg    <= s1_reg.rd_hit ? mem_rd_reg : '0;
            out_pending_reg <= s1_reg.pending;
        end
    end

    // Byte store: one write port for the receive bank, one registered read
    // port for the ready bank.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= req.rx_byte;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_ra];
        end
    end

    // Response outputs.
    assign rsp.valid         = out_valid_reg;
    assign rsp.frame_done    = out_done_reg;
    assign rsp.frame_len     = out_len_reg;
    assign rsp.read_data     = out_data_reg;
    assign rsp.frame_pending = out_pending_reg;

endmodule
